### hdl/sfd_pkg.sv
// Shared types and constants for the socket frame deframer.
package sfd_pkg;

    localparam int unsigned HDR_BYTES = 24;
    localparam int unsigned HDR_BITS  = HDR_BYTES * 8;
    localparam int unsigned CNT_W     = 5;

    localparam logic [31:0] HDR_MAGIC    = 32'h4A56_4950;
    localparam logic [15:0] WIRE_VERSION = 16'd2;

    localparam logic [31:0] MAX_FRAME_RST = 32'd65560;
    localparam logic [63:0] KIND_MASK_RST = {64{1'b1}};

    localparam logic [CNT_W-1:0] LAST_HDR_IDX = CNT_W'(HDR_BYTES - 1);

    // Word operations
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_HDR   = 3'd1;
    localparam logic [2:0] ERR_BAD_VER   = 3'd2;
    localparam logic [2:0] ERR_BAD_KIND  = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MAX_FRAME = 1'b0;
    localparam logic CFG_KIND_MASK = 1'b1;

    typedef struct packed {
        logic [15:0] kind;
        logic [31:0] length;
        logic [63:0] corr;
    } t_hdr_info;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        last;
        logic [15:0] frame_kind;
        logic [63:0] correlation;
        logic [31:0] payload_length;
        logic [2:0]  error_code;
    } t_result;

endpackage

### hdl/sfd_hdr.sv
// Header capture shift register and header checks.
module sfd_hdr (
    input  logic                     i_clk,
    input  logic                     i_shift,
    input  logic [7:0]               i_byte,
    input  logic [31:0]              i_max_frame_bytes,
    input  logic [63:0]              i_known_kind_mask,
    output sfd_pkg::t_hdr_info       o_cur,
    output sfd_pkg::t_hdr_info       o_nxt,
    output logic [2:0]               o_err
);

    logic [sfd_pkg::HDR_BITS-1:0] r_hdr;
    logic [sfd_pkg::HDR_BITS-1:0] w_nxt;
    logic [32:0]                  w_frame_len;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_hdr <= w_nxt;
        end
    end

    // Header as it stands once the incoming word is shifted in
    assign w_nxt = {r_hdr[sfd_pkg::HDR_BITS-9:0], i_byte};

    assign o_cur.kind   = r_hdr[143:128];
    assign o_cur.length = r_hdr[95:64];
    assign o_cur.corr   = r_hdr[63:0];

    assign o_nxt.kind   = w_nxt[143:128];
    assign o_nxt.length = w_nxt[95:64];
    assign o_nxt.corr   = w_nxt[63:0];

    assign w_frame_len = {1'b0, w_nxt[95:64]} + 33'(sfd_pkg::HDR_BYTES);

    always_comb begin
        if (w_nxt[191:160] != sfd_pkg::HDR_MAGIC) begin
            o_err = sfd_pkg::ERR_BAD_HDR;
        end else if (w_nxt[159:144] != sfd_pkg::WIRE_VERSION) begin
            o_err = sfd_pkg::ERR_BAD_VER;
        end else if (w_nxt[127:96] != 32'd0) begin
            o_err = sfd_pkg::ERR_BAD_HDR;
        end else if ((w_nxt[143:134] != 10'd0) || !i_known_kind_mask[w_nxt[133:128]]) begin
            o_err = sfd_pkg::ERR_BAD_KIND;
        end else if (w_frame_len > {1'b0, i_max_frame_bytes}) begin
            o_err = sfd_pkg::ERR_TOO_LARGE;
        end else begin
            o_err = sfd_pkg::ERR_NONE;
        end
    end

endmodule

### hdl/sfd_obuf.sv
// Output result register with valid/ready handshake.
module sfd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sfd_pkg::t_result  i_res,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output sfd_pkg::t_result  o_res
);

    logic             r_valid;
    sfd_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hdl/socket_frame_deframer_core.sv
// Top level of the socket frame deframer: frame control and config registers.
// A result is registered: it appears on o_valid in the cycle after the word that causes it is accepted.
// Throughput: one word per cycle; o_ready drops only while a result waits on i_ready.
// Reset (synchronous, i_rst_n low): clears header count, payload and error state, output
// valid, and returns max_frame_bytes and known_kind_mask to their defaults.
// The header store itself is not reset; it is always filled before it is checked.
module socket_frame_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic [15:0] o_frame_kind,
    output logic [63:0] o_correlation,
    output logic [31:0] o_payload_length,
    output logic [2:0]  o_error_code,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [31:0]                r_max_frame;
    logic [63:0]                r_kind_mask;
    logic [sfd_pkg::CNT_W-1:0]  r_count, n_count;
    logic                       r_in_payload, n_in_payload;
    logic [31:0]                r_left, n_left;
    logic                       r_stuck, n_stuck;

    logic                       w_accept;
    logic                       w_shift;
    logic                       w_emit;
    logic                       w_can_load;
    logic                       w_fin;
    logic [2:0]                 w_err;
    sfd_pkg::t_hdr_info         w_cur;
    sfd_pkg::t_hdr_info         w_nxt;
    sfd_pkg::t_result           w_res;
    sfd_pkg::t_result           w_out;

    assign o_ready  = w_can_load;
    assign w_accept = i_valid && w_can_load;
    assign w_fin    = (r_left <= 32'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= sfd_pkg::MAX_FRAME_RST;
            r_kind_mask <= sfd_pkg::KIND_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfd_pkg::CFG_MAX_FRAME: r_max_frame <= i_cfg_data[31:0];
                sfd_pkg::CFG_KIND_MASK: r_kind_mask <= i_cfg_data;
                default:                r_kind_mask <= r_kind_mask;
            endcase
        end
    end

    always_comb begin
        n_count      = r_count;
        n_in_payload = r_in_payload;
        n_left       = r_left;
        n_stuck      = r_stuck;
        w_shift      = 1'b0;
        w_emit       = 1'b0;
        w_res        = '0;
        w_res.last   = 1'b1;
        if (w_accept) begin
            if (i_op == sfd_pkg::OP_CLEAR) begin
                // clear: drop partial header, payload and error state
                n_count      = '0;
                n_in_payload = 1'b0;
                n_left       = '0;
                n_stuck      = 1'b0;
            end else if (r_stuck) begin
                // drop the word
            end else if (r_in_payload) begin
                w_emit               = 1'b1;
                w_res.payload_byte   = i_data_byte;
                w_res.byte_valid     = 1'b1;
                w_res.last           = w_fin;
                w_res.frame_kind     = w_cur.kind;
                w_res.correlation    = w_cur.corr;
                w_res.payload_length = w_cur.length;
                if (w_fin) begin
                    n_left       = '0;
                    n_in_payload = 1'b0;
                end else begin
                    n_left = r_left - 32'd1;
                end
            end else begin
                w_shift = 1'b1;
                if (r_count == sfd_pkg::LAST_HDR_IDX) begin
                    n_count = '0;
                    if (w_err != sfd_pkg::ERR_NONE) begin
                        n_stuck          = 1'b1;
                        w_emit           = 1'b1;
                        w_res.error_code = w_err;
                    end else if (w_nxt.length == 32'd0) begin
                        w_emit            = 1'b1;
                        w_res.frame_kind  = w_nxt.kind;
                        w_res.correlation = w_nxt.corr;
                    end else begin
                        n_in_payload = 1'b1;
                        n_left       = w_nxt.length;
                    end
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_in_payload <= 1'b0;
            r_left       <= '0;
            r_stuck      <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_in_payload <= n_in_payload;
            r_left       <= n_left;
            r_stuck      <= n_stuck;
        end
    end

    sfd_hdr u_hdr (
        .i_clk             (i_clk),
        .i_shift           (w_shift),
        .i_byte            (i_data_byte),
        .i_max_frame_bytes (r_max_frame),
        .i_known_kind_mask (r_kind_mask),
        .o_cur             (w_cur),
        .o_nxt             (w_nxt),
        .o_err             (w_err)
    );

    sfd_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_emit),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (w_out)
    );

    assign o_payload_byte   = w_out.payload_byte;
    assign o_byte_valid     = w_out.byte_valid;
    assign o_last           = w_out.last;
    assign o_frame_kind     = w_out.frame_kind;
    assign o_correlation    = w_out.correlation;
    assign o_payload_length = w_out.payload_length;
    assign o_error_code     = w_out.error_code;

endmodule

### verif/tb_socket_frame_deframer_core.sv
// Self-checking testbench for the socket frame deframer core.
`timescale 1ns / 1ps

module tb_socket_frame_deframer_core;

    localparam int unsigned RANDOM_WORDS = 1350;
    localparam logic [15:0] GOOD_VER     = sfd_pkg::WIRE_VERSION;

    class deframe_scoreboard;
        logic [7:0]       hdr_bytes [sfd_pkg::HDR_BYTES];
        int unsigned      hdr_fill;
        bit               mid_payload;
        logic [31:0]      bytes_left;
        bit               locked;
        logic [31:0]      frame_limit;
        logic [63:0]      kind_known;
        sfd_pkg::t_result want_q [$];
        int unsigned      fail_count;

        function new();
            foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
            hdr_fill    = 0;
            mid_payload = 1'b0;
            bytes_left  = '0;
            locked      = 1'b0;
            frame_limit = sfd_pkg::MAX_FRAME_RST;
            kind_known  = sfd_pkg::KIND_MASK_RST;
            fail_count  = 0;
        endfunction

        function void set_reg(logic idx, logic [63:0] val);
            if (idx == sfd_pkg::CFG_MAX_FRAME) begin
                frame_limit = val[31:0];
            end else begin
                kind_known = val;
            end
        endfunction

        // Big-endian field of n bytes starting at header offset at.
        function logic [63:0] hdr_field(int unsigned at, int unsigned n);
            logic [63:0] v;
            int unsigned k;
            v = '0;
            for (k = 0; k < n; k++) v = {v[55:0], hdr_bytes[at + k]};
            return v;
        endfunction

        function logic [15:0] hdr_kind();
            logic [63:0] f;
            f = hdr_field(6, 2);
            return f[15:0];
        endfunction

        function logic [31:0] hdr_len();
            logic [63:0] f;
            f = hdr_field(12, 4);
            return f[31:0];
        endfunction

        // Checks in priority order: magic, version, flags, kind, length.
        function logic [2:0] hdr_verdict();
            logic [63:0] kind;
            logic [63:0] len;
            if (hdr_field(0, 4) != 64'(sfd_pkg::HDR_MAGIC)) return sfd_pkg::ERR_BAD_HDR;
            if (hdr_field(4, 2) != 64'(sfd_pkg::WIRE_VERSION)) return sfd_pkg::ERR_BAD_VER;
            if (hdr_field(8, 2) != 64'd0 || hdr_field(10, 2) != 64'd0)
                return sfd_pkg::ERR_BAD_HDR;
            kind = hdr_field(6, 2);
            if (kind >= 64'd64 || !kind_known[kind[5:0]]) return sfd_pkg::ERR_BAD_KIND;
            len = hdr_field(12, 4);
            if (frame_limit < sfd_pkg::HDR_BYTES) return sfd_pkg::ERR_TOO_LARGE;
            if (len > 64'(frame_limit - 32'(sfd_pkg::HDR_BYTES)))
                return sfd_pkg::ERR_TOO_LARGE;
            return sfd_pkg::ERR_NONE;
        endfunction

        function void note_word(logic op, logic [7:0] b);
            sfd_pkg::t_result r;
            logic [2:0]       err;
            r = '0;
            if (op == sfd_pkg::OP_CLEAR) begin
                hdr_fill    = 0;
                mid_payload = 1'b0;
                bytes_left  = '0;
                locked      = 1'b0;
                return;
            end
            if (locked) return;
            if (mid_payload) begin
                r.payload_byte   = b;
                r.byte_valid     = 1'b1;
                r.last           = (bytes_left <= 32'd1);
                r.frame_kind     = hdr_kind();
                r.correlation    = hdr_field(16, 8);
                r.payload_length = hdr_len();
                r.error_code     = sfd_pkg::ERR_NONE;
                if (r.last) begin
                    bytes_left  = '0;
                    mid_payload = 1'b0;
                    hdr_fill    = 0;
                end else begin
                    bytes_left = bytes_left - 32'd1;
                end
                want_q.push_back(r);
                return;
            end
            if (hdr_fill >= sfd_pkg::HDR_BYTES) hdr_fill = 0;
            hdr_bytes[hdr_fill] = b;
            hdr_fill++;
            if (hdr_fill < sfd_pkg::HDR_BYTES) return;
            hdr_fill = 0;
            err = hdr_verdict();
            if (err != sfd_pkg::ERR_NONE) begin
                locked       = 1'b1;
                r.last       = 1'b1;
                r.error_code = err;
                want_q.push_back(r);
                return;
            end
            bytes_left = hdr_len();
            if (bytes_left == 32'd0) begin
                r.last        = 1'b1;
                r.frame_kind  = hdr_kind();
                r.correlation = hdr_field(16, 8);
                r.error_code  = sfd_pkg::ERR_NONE;
                want_q.push_back(r);
            end else begin
                mid_payload = 1'b1;
            end
        endfunction

        function void check_word(sfd_pkg::t_result got);
            sfd_pkg::t_result w;
            if (want_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected: byte %0h bv %0b last %0b kind %0h corr %0h len %0h err %0d",
                             got.payload_byte, got.byte_valid, got.last, got.frame_kind,
                             got.correlation, got.payload_length, got.error_code);
                return;
            end
            w = want_q.pop_front();
            if (got.payload_byte !== w.payload_byte || got.byte_valid !== w.byte_valid ||
                got.last !== w.last || got.frame_kind !== w.frame_kind ||
                got.correlation !== w.correlation || got.payload_length !== w.payload_length ||
                got.error_code !== w.error_code) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("mismatch exp: byte %0h bv %0b last %0b kind %0h corr %0h len %0h err %0d",
                             w.payload_byte, w.byte_valid, w.last, w.frame_kind,
                             w.correlation, w.payload_length, w.error_code);
                    $display("         got: byte %0h bv %0b last %0b kind %0h corr %0h len %0h err %0d",
                             got.payload_byte, got.byte_valid, got.last, got.frame_kind,
                             got.correlation, got.payload_length, got.error_code);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_payload_byte;
    logic        o_byte_valid;
    logic        o_last;
    logic [15:0] o_frame_kind;
    logic [63:0] o_correlation;
    logic [31:0] o_payload_length;
    logic [2:0]  o_error_code;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    deframe_scoreboard sb;
    bit               steady;
    bit               in_fire;
    bit               out_fire;
    bit               rst_seen;
    sfd_pkg::t_result out_seen;
    int unsigned      sent;
    int unsigned      frames;

    socket_frame_deframer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_payload_byte   (o_payload_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last           (o_last),
        .o_frame_kind     (o_frame_kind),
        .o_correlation    (o_correlation),
        .o_payload_length (o_payload_length),
        .o_error_code     (o_error_code),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sample handshakes mid-cycle, act on them at the following edge.
    always @(negedge i_clk) begin
        rst_seen                = i_rst_n;
        in_fire                 = i_valid && o_ready;
        out_fire                = o_valid && i_ready;
        out_seen.payload_byte   = o_payload_byte;
        out_seen.byte_valid     = o_byte_valid;
        out_seen.last           = o_last;
        out_seen.frame_kind     = o_frame_kind;
        out_seen.correlation    = o_correlation;
        out_seen.payload_length = o_payload_length;
        out_seen.error_code     = o_error_code;
    end

    always @(posedge i_clk) begin
        if (rst_seen && out_fire) sb.check_word(out_seen);
    end

    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= 36);
    end

    task automatic send_word(logic op, logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (!in_fire);
        sb.note_word(op, b);
        sent++;
    endtask

    // Let the block drain before touching a register.
    task automatic write_reg(logic idx, logic [63:0] val);
        i_valid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [191:0] make_hdr(logic [15:0] ver, logic [15:0] kind,
                                              logic [15:0] f1, logic [15:0] f2,
                                              logic [31:0] len, logic [63:0] corr);
        return {sfd_pkg::HDR_MAGIC, ver, kind, f1, f2, len, corr};
    endfunction

    task automatic send_hdr(logic [191:0] h);
        int k;
        for (k = 0; k < sfd_pkg::HDR_BYTES; k++)
            send_word(sfd_pkg::OP_BYTE, h[191 - 8 * k -: 8]);
    endtask

    // Header, n trailing bytes, then a clear if the block is stuck or mid-payload.
    task automatic send_frame(logic [191:0] h, int n);
        int k;
        send_hdr(h);
        for (k = 0; k < n; k++) send_word(sfd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        if (sb.locked || sb.mid_payload)
            send_word(sfd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_frame();
        logic [15:0]  ver;
        logic [15:0]  kind;
        logic [15:0]  f1;
        logic [15:0]  f2;
        logic [31:0]  len;
        logic [191:0] h;
        int           n;
        int           k;
        ver  = GOOD_VER;
        kind = 16'($urandom_range(0, 63));
        f1   = '0;
        f2   = '0;
        len  = 32'($urandom_range(0, 12));
        n    = int'(len);
        if ($urandom_range(0, 99) >= 72) begin
            case ($urandom_range(0, 7))
                0: ver = 16'($urandom);
                1: f1 = 16'(1 << $urandom_range(0, 15));
                2: f2 = 16'($urandom_range(1, 65535));
                3: kind = 16'($urandom_range(64, 65535));
                4: begin
                    len = $urandom;
                    n   = $urandom_range(0, 6);
                end
                5: begin
                    h = make_hdr(ver, kind, f1, f2, len, rand64());
                    h[$urandom_range(160, 191)] ^= 1'b1;
                    send_frame(h, $urandom_range(0, 4));
                    return;
                end
                6: begin
                    // drop a partial header
                    h = make_hdr(ver, kind, f1, f2, len, rand64());
                    n = $urandom_range(1, 23);
                    for (k = 0; k < n; k++) send_word(sfd_pkg::OP_BYTE, h[191 - 8 * k -: 8]);
                    send_word(sfd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
                    return;
                end
                default: begin
                    n = $urandom_range(1, 30);
                    for (k = 0; k < n; k++)
                        send_word(sfd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
                    if (sb.locked || sb.mid_payload || $urandom_range(0, 1))
                        send_word(sfd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
                    return;
                end
            endcase
        end
        send_frame(make_hdr(ver, kind, f1, f2, len, rand64()), n);
    endtask

    task automatic random_config();
        logic [31:0] lim;
        logic [63:0] mask;
        case ($urandom_range(0, 9))
            0: lim = 32'd0;
            1: lim = 32'd23;
            2: lim = 32'd24;
            3, 4: lim = 32'($urandom_range(25, 40));
            5: lim = 32'hFFFF_FFFF;
            6: lim = $urandom;
            default: lim = sfd_pkg::MAX_FRAME_RST;
        endcase
        case ($urandom_range(0, 7))
            0: mask = '0;
            1: mask = rand64();
            2: mask = 64'd1 << $urandom_range(0, 63);
            3: mask = rand64() | rand64();
            default: mask = sfd_pkg::KIND_MASK_RST;
        endcase
        if ($urandom_range(0, 2) != 0) write_reg(sfd_pkg::CFG_MAX_FRAME, {$urandom, lim});
        if ($urandom_range(0, 2) != 0) write_reg(sfd_pkg::CFG_KIND_MASK, mask);
    endtask

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int unsigned base;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_op        = sfd_pkg::OP_BYTE;
        i_data_byte = 8'h00;
        i_ready     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = sfd_pkg::CFG_MAX_FRAME;
        i_cfg_data  = '0;
        steady      = 1'b0;
        sent        = 0;
        frames      = 0;
        sb          = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Good frame with extreme payload bytes, then an empty frame.
        send_hdr(make_hdr(GOOD_VER, 16'd0, 16'd0, 16'd0, 32'd3, 64'hFFFF_FFFF_FFFF_FFFF));
        send_word(sfd_pkg::OP_BYTE, 8'h00);
        send_word(sfd_pkg::OP_BYTE, 8'hFF);
        send_word(sfd_pkg::OP_BYTE, 8'h5A);
        send_frame(make_hdr(GOOD_VER, 16'd63, 16'd0, 16'd0, 32'd0, 64'd0), 0);
        // Largest length at the reset limit, cut short by a clear; one past it.
        send_frame(make_hdr(GOOD_VER, 16'd7, 16'd0, 16'd0, 32'd65536, rand64()), 4);
        send_frame(make_hdr(GOOD_VER, 16'd7, 16'd0, 16'd0, 32'd65537, rand64()), 3);
        send_frame(make_hdr(GOOD_VER, 16'd1, 16'd0, 16'd0, 32'd1, rand64())
                   ^ {8'h01, 184'd0}, 2);
        send_frame(make_hdr(16'd3, 16'd1, 16'd0, 16'd0, 32'd1, rand64()), 2);
        send_frame(make_hdr(GOOD_VER, 16'd1, 16'h8000, 16'd0, 32'd1, rand64()), 1);
        send_frame(make_hdr(GOOD_VER, 16'd1, 16'd0, 16'h0001, 32'd1, rand64()), 1);
        send_frame(make_hdr(GOOD_VER, 16'd64, 16'd0, 16'd0, 32'd1, rand64()), 1);
        send_frame(make_hdr(GOOD_VER, 16'hFFFF, 16'd0, 16'd0, 32'd1, rand64()), 1);
        // Clear in the middle of a header.
        repeat (10) send_word(sfd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        send_word(sfd_pkg::OP_CLEAR, 8'hFF);
        send_frame(make_hdr(GOOD_VER, 16'd2, 16'd0, 16'd0, 32'd1, rand64()), 1);

        write_reg(sfd_pkg::CFG_KIND_MASK, 64'd0);
        send_frame(make_hdr(GOOD_VER, 16'd5, 16'd0, 16'd0, 32'd0, rand64()), 1);
        write_reg(sfd_pkg::CFG_KIND_MASK, 64'd1 << 63);
        send_frame(make_hdr(GOOD_VER, 16'd63, 16'd0, 16'd0, 32'd0, rand64()), 0);
        send_frame(make_hdr(GOOD_VER, 16'd62, 16'd0, 16'd0, 32'd0, rand64()), 1);
        write_reg(sfd_pkg::CFG_KIND_MASK, sfd_pkg::KIND_MASK_RST);
        write_reg(sfd_pkg::CFG_MAX_FRAME, 64'd23);
        send_frame(make_hdr(GOOD_VER, 16'd3, 16'd0, 16'd0, 32'd0, rand64()), 1);
        write_reg(sfd_pkg::CFG_MAX_FRAME, 64'd24);
        send_frame(make_hdr(GOOD_VER, 16'd3, 16'd0, 16'd0, 32'd0, rand64()), 0);
        send_frame(make_hdr(GOOD_VER, 16'd3, 16'd0, 16'd0, 32'd1, rand64()), 1);
        write_reg(sfd_pkg::CFG_MAX_FRAME, 64'd0);
        send_frame(make_hdr(GOOD_VER, 16'd3, 16'd0, 16'd0, 32'd0, rand64()), 1);
        write_reg(sfd_pkg::CFG_MAX_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(make_hdr(GOOD_VER, 16'd9, 16'd0, 16'd0, 32'hFFFF_FFFF, rand64()), 3);
        write_reg(sfd_pkg::CFG_MAX_FRAME, {32'd0, sfd_pkg::MAX_FRAME_RST});

        base = sent;
        while (sent < base + RANDOM_WORDS) begin
            // hold both sides busy through one long stretch
            steady = (sent >= base + 800) && (sent < base + 1100);
            frames++;
            if (frames % 6 == 0) random_config();
            random_frame();
        end
        steady = 1'b0;

        i_valid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.want_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
hdl/sfd_pkg.sv
hdl/sfd_hdr.sv
hdl/sfd_obuf.sv
hdl/socket_frame_deframer_core.sv
verif/tb_socket_frame_deframer_core.sv
